FILE: rtl/core/rse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg
// shared constants, types and GF(256) arithmetic for the RS encoder
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int MAX_PARITY_DEF = 32;

  localparam int PC_W       = 6;
  localparam int FP_W       = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [PC_W-1:0] PC_RESET   = 6'd16;
  localparam logic [7:0]      RED_RESET  = 8'h1D;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY   = 2'd1;

  typedef struct packed {
    logic [7:0] sym;
    logic       is_parity;
    logic       eoc;
  } res_t;

  typedef struct packed {
    logic clear;
    logic update;
    logic shift;
  } lfsr_ctrl_t;

  // multiply in GF(256), red holds the low byte of the field polynomial
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] red);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? red : 8'h00);
    end
    return acc;
  endfunction

  // multiply by the constant 2
  function automatic logic [7:0] gf_xtime(input logic [7:0] a, input logic [7:0] red);
    return {a[6:0], 1'b0} ^ (a[7] ? red : 8'h00);
  endfunction

  // clamp a raw parity count to 1..maxp
  function automatic int sat_count(input logic [PC_W-1:0] pc, input int maxp);
    int v;
    v = int'(pc);
    if (v < 1) v = 1;
    if (v > maxp) v = maxp;
    return v;
  endfunction

endpackage

FILE: rtl/core/reed_solomon_systematic_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reed_solomon_systematic_encoder
// systematic RS encoder over GF(256) with configurable parity count and field
// ----------------------------------------------------------------------------
// usage:
//   message bytes enter on the in_ channel, highest-degree symbol first, with
//   in_last_byte set on the final one. every data beat is echoed on the out_
//   channel through the output buffer (out_is_parity low). after the last
//   data beat the n parity beats follow, highest degree first, the final one
//   flagged by out_end_of_codeword.
//   throughput: one beat per cycle while neither channel stalls; a message of
//   L bytes occupies the input for its L beats and in_stall is held high while
//   the n parity beats drain, since all beats share the single output port.
//   the generator is rebuilt one factor per cycle by a shared multiplier row:
//   after reset and after each accepted config write in_stall stays high
//   until the rebuild is done. a config write also clears the parity remainder.
//   the result side has a two-entry skid buffer: when out_stall rises the
//   pending beat holds on the outputs, one more beat may still be taken into
//   the skid entry, then in_stall goes high until the receiver drains it.
// ----------------------------------------------------------------------------
module reed_solomon_systematic_encoder #(
  parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_is_parity,
  output logic                           out_end_of_codeword,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [rse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rse_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rse_pkg::*;

  localparam int NW = $clog2(MAX_PARITY + 1);

  // configuration state
  logic [NW-1:0] n_r;        // active parity count, already clamped
  logic [7:0]    red_r;      // low byte of the field polynomial
  logic          cfg_hit;

  // flow control
  logic          gen_busy;
  logic          can_push;
  logic          in_acc;
  logic          draining;
  logic          drain_go;
  logic [NW-1:0] drain_cnt_r;
  logic [NW-1:0] drain_cnt_nxt;

  // datapath
  logic [7:0]    coef [MAX_PARITY];
  logic [7:0]    top_byte;
  lfsr_ctrl_t    lfsr_ctrl;
  res_t          push_data;
  res_t          out_data;
  logic          push;

  // only listed registers take effect; other indexes are ignored
  assign cfg_hit = cfg_we && (cfg_index == CFG_PARITY_COUNT || cfg_index == CFG_FIELD_POLY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= NW'(sat_count(PC_RESET, MAX_PARITY));
      red_r <= RED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PARITY_COUNT: n_r   <= NW'(sat_count(cfg_data[PC_W-1:0], MAX_PARITY));
        CFG_FIELD_POLY:   red_r <= cfg_data[7:0];   // bit 8 is implied
        default: ;
      endcase
    end
  end

  // input is held off while the generator rebuilds, during parity drain and
  // while the skid entry is occupied
  assign draining = (drain_cnt_r != '0);
  assign in_stall = gen_busy || draining || !can_push;
  assign in_acc   = in_valid && !in_stall;
  assign drain_go = draining && can_push;

  always_comb begin
    drain_cnt_nxt = drain_cnt_r;
    if (cfg_hit) begin
      drain_cnt_nxt = '0;   // message in progress is abandoned
    end else if (in_acc && in_last_byte) begin
      drain_cnt_nxt = n_r;
    end else if (drain_go) begin
      drain_cnt_nxt = drain_cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_cnt_r <= '0;
    end else begin
      drain_cnt_r <= drain_cnt_nxt;
    end
  end

  // parity register: update on a data beat, shift up on each parity beat
  assign lfsr_ctrl.clear  = cfg_hit;
  assign lfsr_ctrl.update = in_acc;
  assign lfsr_ctrl.shift  = drain_go;

  rse_gen #(
    .MAX_PARITY (MAX_PARITY),
    .NW         (NW)
  ) u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_hit),
    .n     (n_r),
    .red   (red_r),
    .busy  (gen_busy),
    .coef  (coef)
  );

  rse_lfsr #(
    .MAX_PARITY (MAX_PARITY),
    .NW         (NW)
  ) u_lfsr (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lfsr_ctrl),
    .data_byte (in_data_byte),
    .n         (n_r),
    .red       (red_r),
    .coef      (coef),
    .top_byte  (top_byte)
  );

  // result beat: echo of the data byte, or the top parity tap while draining
  assign push = in_acc || drain_go;

  always_comb begin
    if (in_acc) begin
      push_data.sym       = in_data_byte;
      push_data.is_parity = 1'b0;
      push_data.eoc       = 1'b0;
    end else begin
      push_data.sym       = top_byte;
      push_data.is_parity = 1'b1;
      push_data.eoc       = (drain_cnt_r == NW'(1));
    end
  end

  rse_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_byte            = out_data.sym;
  assign out_is_parity       = out_data.is_parity;
  assign out_end_of_codeword = out_data.eoc;

  // a last data beat arms the drain with exactly n parity beats
  a_drain_arm: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte && !cfg_hit) |=> (drain_cnt_r == $past(n_r)))
    else $error("parity drain not armed with the active count");

  // no data beat is taken during parity drain or generator rebuild
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (draining || gen_busy) |-> !in_acc)
    else $error("input accepted while draining or rebuilding");

  // end of codeword only ever marks a parity beat
  a_eoc_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_end_of_codeword || out_is_parity))
    else $error("end of codeword on a data beat");

  // the drain counter only steps down while a parity beat is pushed
  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (draining && !can_push && !cfg_hit) |=> $stable(drain_cnt_r))
    else $error("parity drain advanced without room in the output buffer");

endmodule

FILE: rtl/core/rse_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_gen
// builds the generator polynomial, one (x + 2^i) factor per cycle
// ----------------------------------------------------------------------------
module rse_gen #(
  parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF,
  parameter int NW         = $clog2(MAX_PARITY + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] n,
  input  logic [7:0]    red,
  output logic          busy,
  output logic [7:0]    coef [MAX_PARITY]
);
  import rse_pkg::*;

  logic [7:0]    poly_r   [MAX_PARITY+1];
  logic [7:0]    poly_nxt [MAX_PARITY+1];
  logic [7:0]    root_r;
  logic [NW-1:0] step_r;
  logic          busy_r;

  always_comb begin
    poly_nxt[0] = gf_mul(root_r, poly_r[0], red);
    for (int j = 1; j <= MAX_PARITY; j++) begin
      poly_nxt[j] = poly_r[j-1] ^ gf_mul(root_r, poly_r[j], red);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      busy_r <= 1'b1;
      step_r <= '0;
      root_r <= 8'h01;
      for (int j = 0; j <= MAX_PARITY; j++) begin
        poly_r[j] <= (j == 0) ? 8'h01 : 8'h00;
      end
    end else if (busy_r) begin
      if (step_r == n) begin
        busy_r <= 1'b0;
      end else begin
        poly_r <= poly_nxt;
        root_r <= gf_xtime(root_r, red);
        step_r <= step_r + NW'(1);
      end
    end
  end

  assign busy = busy_r;

  always_comb begin
    for (int j = 0; j < MAX_PARITY; j++) begin
      coef[j] = poly_r[j];
    end
  end

endmodule

FILE: rtl/core/rse_lfsr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_lfsr
// parity remainder register: byte update and parity drain shift
// ----------------------------------------------------------------------------
module rse_lfsr #(
  parameter int MAX_PARITY = rse_pkg::MAX_PARITY_DEF,
  parameter int NW         = $clog2(MAX_PARITY + 1),
  parameter int IW         = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rse_pkg::lfsr_ctrl_t ctrl,
  input  logic [7:0]          data_byte,
  input  logic [NW-1:0]       n,
  input  logic [7:0]          red,
  input  logic [7:0]          coef [MAX_PARITY],
  output logic [7:0]          top_byte
);
  import rse_pkg::*;

  logic [7:0]    par_r   [MAX_PARITY];
  logic [7:0]    par_upd [MAX_PARITY];
  logic [7:0]    par_shf [MAX_PARITY];
  logic [7:0]    fb;
  logic [IW-1:0] top_idx;

  assign top_idx  = IW'(n - NW'(1));
  assign top_byte = par_r[top_idx];
  assign fb       = data_byte ^ top_byte;

  always_comb begin
    par_upd[0] = gf_mul(fb, coef[0], red);
    par_shf[0] = 8'h00;
    for (int i = 1; i < MAX_PARITY; i++) begin
      par_upd[i] = par_r[i-1] ^ gf_mul(fb, coef[i], red);
      par_shf[i] = par_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      for (int i = 0; i < MAX_PARITY; i++) par_r[i] <= 8'h00;
    end else if (ctrl.update) begin
      par_r <= par_upd;
    end else if (ctrl.shift) begin
      par_r <= par_shf;
    end
  end

endmodule

FILE: rtl/core/rse_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_obuf
// two-entry output skid buffer for the result channel
// ----------------------------------------------------------------------------
module rse_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rse_pkg::res_t push_data,
  output logic          can_push,
  output logic          out_valid,
  input  logic          out_stall,
  output rse_pkg::res_t out_data
);
  import rse_pkg::*;

  res_t main_r;
  res_t skid_r;
  logic main_valid_r;
  logic skid_valid_r;
  logic pop;

  assign pop      = main_valid_r && !out_stall;
  assign can_push = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_r       <= push_data;
        main_valid_r <= 1'b1;
      end else begin
        skid_r       <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the systematic rs encoder: a scoreboard class keeps
// its own copy of the generator and the parity remainder, predicts every echo
// and parity beat of each codeword, and compares the output stream field by
// field while both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb_top;
  import rse_pkg::*;

  localparam int NPAR_MAX = MAX_PARITY_DEF;
  localparam logic [7:0] ROOT_STEP = 8'h02;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 2 * NPAR_MAX + 8;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_BEATS = 10;

  // --------------------------------------------------------------------------
  // codeword predictor and expected beat store
  // --------------------------------------------------------------------------
  class rs_codeword_scoreboard;
    logic [7:0]      remainder [NPAR_MAX];
    logic [7:0]      gen_coef [NPAR_MAX];
    logic [PC_W-1:0] count_reg;
    logic [7:0]      reduction;
    res_t            codeword_q [$];
    int              errors;

    function new();
      count_reg = PC_RESET;
      reduction = RED_RESET;
      errors    = 0;
      clear_remainder();
      build_generator();
    endfunction

    function int active_parity();
      int n;
      n = int'(count_reg);
      if (n < 1) n = 1;
      if (n > NPAR_MAX) n = NPAR_MAX;
      return n;
    endfunction

    // horner style multiply, msb of b first
    function logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      int k;
      acc = 8'h00;
      for (k = 7; k >= 0; k--) begin
        acc = {acc[6:0], 1'b0} ^ (acc[7] ? reduction : 8'h00);
        if (b[k]) acc = acc ^ a;
      end
      return acc;
    endfunction

    function void clear_remainder();
      int i;
      for (i = 0; i < NPAR_MAX; i++) remainder[i] = 8'h00;
    endfunction

    // g(x) = prod (x + 2^i), monic term implied
    function void build_generator();
      logic [7:0] poly [NPAR_MAX+1];
      logic [7:0] root;
      int n, i, j;
      n = active_parity();
      for (j = 0; j <= NPAR_MAX; j++) poly[j] = 8'h00;
      poly[0] = 8'h01;
      root = 8'h01;
      for (i = 0; i < n; i++) begin
        for (j = i + 1; j > 0; j--) poly[j] = poly[j-1] ^ field_mul(root, poly[j]);
        poly[0] = field_mul(root, poly[0]);
        root = field_mul(root, ROOT_STEP);
      end
      for (j = 0; j < NPAR_MAX; j++) gen_coef[j] = (j < n) ? poly[j] : 8'h00;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_PARITY_COUNT) count_reg = value[PC_W-1:0];
      else if (idx == CFG_FIELD_POLY) reduction = value[7:0];
      else return;
      clear_remainder();
      build_generator();
    endfunction

    function void note_input(logic [7:0] d, logic last);
      res_t r;
      logic [7:0] fb;
      int n, i;
      n = active_parity();
      r.sym = d;
      r.is_parity = 1'b0;
      r.eoc = 1'b0;
      codeword_q.push_back(r);
      fb = d ^ remainder[n-1];
      for (i = n - 1; i > 0; i--) remainder[i] = remainder[i-1] ^ field_mul(fb, gen_coef[i]);
      remainder[0] = field_mul(fb, gen_coef[0]);
      if (last) begin
        for (i = 0; i < n; i++) begin
          r.sym = remainder[n-1-i];
          r.is_parity = 1'b1;
          r.eoc = (i == n - 1);
          codeword_q.push_back(r);
        end
        clear_remainder();
      end
    endfunction

    function int pending();
      return codeword_q.size();
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] b, logic p, logic e);
      res_t want;
      if (codeword_q.size() == 0) begin
        report($sformatf("unexpected beat byte=%02h parity=%0b end=%0b", b, p, e));
        return;
      end
      want = codeword_q.pop_front();
      if (b !== want.sym)
        report($sformatf("out_byte %02h, want %02h", b, want.sym));
      if (p !== want.is_parity)
        report($sformatf("out_is_parity %0b, want %0b (byte %02h)", p, want.is_parity, want.sym));
      if (e !== want.eoc)
        report($sformatf("out_end_of_codeword %0b, want %0b (byte %02h)", e, want.eoc, want.sym));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // dut and its signals
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_data_byte;
  logic                  in_last_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_byte;
  logic                  out_is_parity;
  logic                  out_end_of_codeword;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  reed_solomon_systematic_encoder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_is_parity       (out_is_parity),
    .out_end_of_codeword (out_end_of_codeword),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  rs_codeword_scoreboard sb;
  logic idle_on;        // random gaps and stalls allowed
  int   beats_sent;
  int   cycle_count;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL reed_solomon_systematic_encoder");
      $finish;
    end
  end

  // receiver: random stall bursts, driven on the falling edge
  initial begin : result_stall
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst = burst - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 7) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: sample at the rising edge, check just after so that a beat
  // taken on the input at the same edge is already noted
  initial begin : result_monitor
    logic [7:0] b;
    logic p, e;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        b = out_byte;
        p = out_is_parity;
        e = out_end_of_codeword;
        #1;
        sb.check_result(b, p, e);
      end
    end
  end

  // --------------------------------------------------------------------------
  // drive tasks
  // --------------------------------------------------------------------------

  // drop valid so that the last beat is not taken twice
  task pause_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task drain_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // config writes only with nothing in flight and no generator rebuild running
  task write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    pause_input();
    drain_results();
    while (in_stall) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.write_register(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task send_beat(logic [7:0] d, logic last);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(d, last);
    beats_sent++;
  endtask

  // random message body; with_last low leaves the codeword open
  task send_message(int len, logic with_last);
    int k;
    for (k = 0; k < len; k++) send_beat(8'($urandom_range(0, 255)), with_last && (k == len - 1));
  endtask

  function logic [CFG_DATA_W-1:0] random_count_value();
    logic [PC_W-1:0] pc;
    case ($urandom_range(0, 9))
      0:       pc = 6'd0;
      1:       pc = 6'd1;
      2:       pc = 6'd32;
      3:       pc = 6'd63;
      default: pc = 6'($urandom_range(1, 32));
    endcase
    // upper bits of the data word are don't-care for the count register
    return {3'($urandom_range(0, 7)), pc};
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] count_value;
    int phase, start, len;
    logic paused_once;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_PARITY_COUNT;
    cfg_data     = '0;
    idle_on      = 1'b1;
    beats_sent   = 0;
    cycle_count  = 0;
    paused_once  = 1'b0;
    sb = new();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: 16 parity, 0x11d
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h01, 1'b1);              // one-byte message

    // smallest parity count
    write_config(CFG_PARITY_COUNT, 9'd1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h7F, 1'b1);

    // largest parity count, incl. an all-zero codeword
    write_config(CFG_PARITY_COUNT, 9'd32);
    send_beat(8'hA5, 1'b1);
    send_beat(8'h00, 1'b1);

    // count zero saturates up to one
    write_config(CFG_PARITY_COUNT, 9'd0);
    send_beat(8'h5A, 1'b0);
    send_beat(8'hC3, 1'b1);

    // count above the maximum saturates down
    write_config(CFG_PARITY_COUNT, 9'd63);
    send_beat(8'hFF, 1'b1);

    // polynomial given without bit 8
    write_config(CFG_PARITY_COUNT, 9'd8);
    write_config(CFG_FIELD_POLY, 9'h01D);
    send_beat(8'h12, 1'b0);
    send_beat(8'h34, 1'b1);

    // non-primitive polynomials, extremes of the field
    write_config(CFG_FIELD_POLY, 9'h100);
    send_beat(8'h80, 1'b0);
    send_beat(8'h81, 1'b1);
    write_config(CFG_FIELD_POLY, 9'h1FF);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFE, 1'b1);

    // config write in the middle of a message abandons it
    write_config(CFG_FIELD_POLY, 9'h12B);
    send_beat(8'h11, 1'b0);
    send_beat(8'h22, 1'b0);
    write_config(CFG_PARITY_COUNT, 9'd4);
    send_beat(8'h33, 1'b1);

    // write to an unused index has no effect
    write_config(CFG_UNUSED, 9'h1FF);
    send_beat(8'h44, 1'b0);
    send_beat(8'h55, 1'b1);

    // codeword longer than 255 symbols: 254 data plus 2 parity
    write_config(CFG_PARITY_COUNT, 9'd2);
    write_config(CFG_FIELD_POLY, 9'h11D);
    send_message(254, 1'b1);

    // random phases, each with its own configuration
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 9) < 7);
      count_value = random_count_value();
      write_config(CFG_PARITY_COUNT, count_value);
      if ($urandom_range(0, 1) == 1) write_config(CFG_FIELD_POLY, 9'($urandom_range(0, 511)));
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) begin
          // broken message: cut off by a rewrite of the count
          send_message(len, 1'b0);
          write_config(CFG_PARITY_COUNT, count_value);
        end else begin
          send_message(len, 1'b1);
        end
        // hold the sender once until the output side has caught up
        if (phase == 1 && !paused_once) begin
          pause_input();
          drain_results();
          paused_once = 1'b1;
        end
      end
    end

    // wind down
    pause_input();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    #2;
    if (sb.pending() != 0) sb.report($sformatf("%0d beats never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("PASS reed_solomon_systematic_encoder");
    end else begin
      $display("FAIL reed_solomon_systematic_encoder");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rse_pkg.sv
rtl/core/rse_gen.sv
rtl/core/rse_lfsr.sv
rtl/core/rse_obuf.sv
rtl/core/reed_solomon_systematic_encoder.sv
tb/tb_top.sv
